// ===== design/ttcw_pkg.sv =====
// Package for the text terminal character writer.
// Holds the request/response item types and the character and command codes.
// No dependencies.
`timescale 1ns / 1ps

package ttcw_pkg;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Character codes
  localparam logic [7:0] CH_BS          = 8'h08;
  localparam logic [7:0] CH_LF          = 8'h0A;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CH_LAST_PRINT  = 8'd126;
  localparam logic [6:0] CH_SPACE       = 7'h20;

  // Request item
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_item_t;

  // Response item
  typedef struct packed {
    logic [6:0] cell_char;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic       did_scroll;
  } rsp_item_t;

endpackage

// ===== design/text_terminal_char_writer_top.sv =====
// Text terminal character writer: character-cell screen fed one byte per item,
// with a cell read command for the display side. Single module.
// Depends on ttcw_pkg.
//
//   channel | handshake            | payload            | direction
//   --------+----------------------+--------------------+----------
//   request | req_valid, req_stall | req  (req_item_t)  | in
//   result  | rsp_valid, rsp_stall | rsp  (rsp_item_t)  | out
//
// Each item passes accept, address, execute and finish steps, and a new item is
// accepted only once the last one is through. A byte that scrolls adds a blank
// step while the screen memory's single write port blanks the new last row.
// After reset the same port clears the whole screen with req_stall high. A held
// result does not block the next item until that item reaches its finish step.
`timescale 1ns / 1ps

module text_terminal_char_writer_top #(
  parameter int NUM_COLS = 80,
  parameter int NUM_ROWS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ttcw_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ttcw_pkg::rsp_item_t rsp
);
  import ttcw_pkg::*;

  localparam int CW        = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int RW        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SW        = ((RW > 5) ? RW : 5) + 1;
  localparam int AW        = RW + CW;
  localparam int MEM_DEPTH = NUM_ROWS * (2 ** CW);

  localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_EXEC,
    S_BLANK,
    S_FIN
  } state_t;

  state_t          state;
  req_item_t       req_q;
  logic [CW-1:0]   cursor_col;
  logic [RW-1:0]   cursor_row;
  logic [RW-1:0]   top_row;
  logic [RW-1:0]   sweep_row;
  logic [CW-1:0]   sweep_col;
  logic [AW-1:0]   mem_addr;
  logic            in_range;
  logic            scrolled;
  logic [6:0]      rd_data;

  logic [6:0]      mem [MEM_DEPTH];

  // Ring row lookup and address for the item being worked on
  logic [SW-1:0]   row_src;
  logic [SW-1:0]   row_sum;
  logic [RW-1:0]   phys_row;
  logic [CW-1:0]   col_src;

  always_comb begin
    if (req_q.cmd == CMD_READ) begin
      row_src = SW'(req_q.read_row);
      col_src = CW'(req_q.read_col);
    end else begin
      row_src = SW'(cursor_row);
      col_src = cursor_col;
    end
    row_sum = SW'(top_row) + row_src;
    if (row_sum >= SW'(NUM_ROWS)) begin
      phys_row = RW'(row_sum - SW'(NUM_ROWS));
    end else begin
      phys_row = RW'(row_sum);
    end
  end

  // Byte decode: cursor motion, cell store, scroll request
  logic [CW-1:0]   col_next;
  logic [RW-1:0]   row_next;
  logic            scroll_next;
  logic            print_we;

  always_comb begin
    col_next    = cursor_col;
    row_next    = cursor_row;
    scroll_next = 1'b0;
    print_we    = 1'b0;
    if (req_q.cmd == CMD_WRITE) begin
      if (req_q.data_byte == CH_LF) begin
        col_next = '0;
        if (cursor_row == LAST_ROW) begin
          scroll_next = 1'b1;
        end else begin
          row_next = cursor_row + 1'b1;
        end
      end else if (req_q.data_byte == CH_CR) begin
        col_next = '0;
      end else if (req_q.data_byte == CH_BS) begin
        if (cursor_col != '0) begin
          col_next = cursor_col - 1'b1;
        end
      end else if (req_q.data_byte inside {[CH_FIRST_PRINT : CH_LAST_PRINT]}) begin
        print_we = 1'b1;
        if (cursor_col == LAST_COL) begin
          // wrap to the next line, scrolling on the last row
          col_next = '0;
          if (cursor_row == LAST_ROW) begin
            scroll_next = 1'b1;
          end else begin
            row_next = cursor_row + 1'b1;
          end
        end else begin
          col_next = cursor_col + 1'b1;
        end
      end
    end
  end

  // Screen memory write port: clear sweep, row blank, or character store
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [6:0]      mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {sweep_row, sweep_col};
    mem_wd = CH_SPACE;
    case (state)
      S_CLEAR, S_BLANK: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        mem_we = print_we;
        mem_wa = mem_addr;
        mem_wd = req_q.data_byte[6:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state == S_EXEC) begin
      rd_data <= mem[mem_addr];
    end
  end

  assign req_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cursor_col <= '0;
      cursor_row <= '0;
      top_row    <= '0;
      sweep_row  <= '0;
      sweep_col  <= '0;
      scrolled   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      // result taken; the finish step sets valid itself when it reloads
      if (rsp_valid && !rsp_stall && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sweep_col == LAST_COL) begin
            sweep_col <= '0;
            if (sweep_row == LAST_ROW) begin
              state <= S_IDLE;
            end else begin
              sweep_row <= sweep_row + 1'b1;
            end
          end else begin
            sweep_col <= sweep_col + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          mem_addr <= {phys_row, col_src};
          in_range <= (int'(req_q.read_row) < NUM_ROWS) &&
                      (int'(req_q.read_col) < NUM_COLS);
          state    <= S_EXEC;
        end
        S_EXEC: begin
          cursor_col <= col_next;
          cursor_row <= row_next;
          scrolled   <= scroll_next;
          if (scroll_next) begin
            // new last row lives in the slot of the old top row
            top_row   <= (top_row == LAST_ROW) ? '0 : top_row + 1'b1;
            sweep_row <= top_row;
            sweep_col <= '0;
            state     <= S_BLANK;
          end else begin
            state <= S_FIN;
          end
        end
        S_BLANK: begin
          if (sweep_col == LAST_COL) begin
            state <= S_FIN;
          end else begin
            sweep_col <= sweep_col + 1'b1;
          end
        end
        S_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            rsp.cell_char  <= (req_q.cmd == CMD_READ && in_range) ? rd_data : 7'd0;
            rsp.cur_col    <= 7'(cursor_col);
            rsp.cur_row    <= 5'(cursor_row);
            rsp.did_scroll <= scrolled;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/text_terminal_char_writer_top_tb.sv =====
// Self-checking testbench for the text terminal character writer.
// Predicts every result from its own copy of the screen and cursor.
// Depends on ttcw_pkg and text_terminal_char_writer_top.
`timescale 1ns / 1ps

module text_terminal_char_writer_top_tb;
  import ttcw_pkg::*;

  localparam int NUM_COLS   = 80;
  localparam int NUM_ROWS   = 24;
  localparam int RAND_ITEMS = 550;
  localparam int IDLE_LIMIT = 20000;

  // Screen image, cursor and queue of expected results
  class screen_scoreboard;
    logic [6:0]  cells [NUM_ROWS*NUM_COLS];
    int unsigned top_base;
    int unsigned col;
    int unsigned row;
    rsp_item_t   expected_q[$];
    int          errors;
    int          checked;
    int          scrolls;
    int          wraps;

    function new();
      foreach (cells[i]) cells[i] = CH_SPACE;
      top_base = 0;
      col      = 0;
      row      = 0;
      errors   = 0;
      checked  = 0;
      scrolls  = 0;
      wraps    = 0;
    endfunction

    // Cursor down one row; on the last row the ring rotates and the new
    // bottom row is blanked. Returns 1 when the screen scrolled.
    function bit line_down();
      int unsigned base;
      if (row + 1 >= NUM_ROWS) begin
        row      = NUM_ROWS - 1;
        top_base = (top_base + 1) % NUM_ROWS;
        base     = ((top_base + NUM_ROWS - 1) % NUM_ROWS) * NUM_COLS;
        for (int c = 0; c < NUM_COLS; c++) cells[base + c] = CH_SPACE;
        scrolls++;
        return 1'b1;
      end
      row++;
      return 1'b0;
    endfunction

    // Apply one accepted request and queue the result it should produce
    function void note_request(req_item_t r);
      rsp_item_t e;
      e = '0;
      if (r.cmd == CMD_READ) begin
        if (r.read_row < NUM_ROWS && r.read_col < NUM_COLS)
          e.cell_char = cells[((top_base + r.read_row) % NUM_ROWS) * NUM_COLS + r.read_col];
      end else if (r.data_byte == CH_LF) begin
        col          = 0;
        e.did_scroll = line_down();
      end else if (r.data_byte == CH_CR) begin
        col = 0;
      end else if (r.data_byte == CH_BS) begin
        if (col > 0) col--;
      end else if (r.data_byte >= CH_FIRST_PRINT && r.data_byte <= CH_LAST_PRINT) begin
        cells[((top_base + row) % NUM_ROWS) * NUM_COLS + col] = r.data_byte[6:0];
        col++;
        // right-edge wrap
        if (col >= NUM_COLS) begin
          col          = 0;
          wraps++;
          e.did_scroll = line_down();
        end
      end
      e.cur_col = col[6:0];
      e.cur_row = row[4:0];
      expected_q.push_back(e);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_response(rsp_item_t a);
      rsp_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result cell=%0d col=%0d row=%0d scroll=%0d",
                 $time, a.cell_char, a.cur_col, a.cur_row, a.did_scroll);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (a.cell_char !== e.cell_char) begin
        $display("%0t: cell_char expected %0d actual %0d", $time, e.cell_char, a.cell_char);
        errors++;
      end
      if (a.cur_col !== e.cur_col) begin
        $display("%0t: cur_col expected %0d actual %0d", $time, e.cur_col, a.cur_col);
        errors++;
      end
      if (a.cur_row !== e.cur_row) begin
        $display("%0t: cur_row expected %0d actual %0d", $time, e.cur_row, a.cur_row);
        errors++;
      end
      if (a.did_scroll !== e.did_scroll) begin
        $display("%0t: did_scroll expected %0d actual %0d", $time, e.did_scroll, a.did_scroll);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  screen_scoreboard sb = new();
  bit       quiet;        // no idling on either side while set
  int       idle_cycles = 0;
  int       accepted = 0;
  int       effective;

  text_terminal_char_writer_top #(
    .NUM_COLS(NUM_COLS),
    .NUM_ROWS(NUM_ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #1 clk = ~clk;

  // Receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 30);
    end
  end

  // Monitor: check results, record requests, watchdog
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      sb.check_response(rsp);
    end
    if (!rst && req_valid === 1'b1 && req_stall === 1'b0) begin
      sb.note_request(req);
      accepted++;
    end
    if (!rst && ((req_valid === 1'b1 && req_stall === 1'b0) ||
                 (rsp_valid === 1'b1 && rsp_stall === 1'b0))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still expected",
               $time, sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_item_t make_req(logic cmd, logic [7:0] data,
                                         logic [4:0] rrow, logic [6:0] rcol);
    req_item_t r;
    r.cmd       = cmd;
    r.data_byte = data;
    r.read_row  = rrow;
    r.read_col  = rcol;
    return r;
  endfunction

  // Present one item, with random idle cycles ahead of it, until accepted
  task automatic send_item(input req_item_t item);
    @(negedge clk);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 30) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!(req_valid === 1'b1 && req_stall === 1'b0)) @(posedge clk);
  endtask

  task automatic send_write(input logic [7:0] data);
    send_item(make_req(CMD_WRITE, data, 5'($urandom_range(0, 31)),
                       7'($urandom_range(0, 127))));
    effective++;
  endtask

  task automatic send_read(input logic [4:0] rrow, input logic [6:0] rcol);
    send_item(make_req(CMD_READ, 8'($urandom_range(0, 255)), rrow, rcol));
    effective++;
  endtask

  // Edge cases of the fields and every kind of byte
  task automatic run_directed();
    send_read(5'd0, 7'd0);
    send_read(5'd23, 7'd79);
    send_read(5'd24, 7'd0);                             // row past the bottom
    send_read(5'd0, 7'd80);                             // column past the edge
    send_item(make_req(CMD_READ, 8'hFF, 5'd31, 7'd127));
    send_item(make_req(CMD_WRITE, CH_BS, 5'd0, 7'd0));  // backspace at column 0
    send_item(make_req(CMD_WRITE, CH_FIRST_PRINT, 5'd31, 7'd127));
    send_item(make_req(CMD_WRITE, CH_LAST_PRINT, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, 8'd127, 5'd0, 7'd0)); // DEL is ignored
    send_item(make_req(CMD_WRITE, 8'd0, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, 8'd255, 5'd31, 7'd127));
    send_item(make_req(CMD_WRITE, 8'd128, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, 8'h09, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, 8'd31, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, "A", 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, CH_BS, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, "B", 5'd0, 7'd0));
    send_read(5'd0, 7'd1);
    send_read(5'd0, 7'd2);
    send_item(make_req(CMD_WRITE, CH_CR, 5'd0, 7'd0));
    send_read(5'd0, 7'd0);
    send_item(make_req(CMD_WRITE, CH_LF, 5'd0, 7'd0));
    send_item(make_req(CMD_WRITE, "Z", 5'd0, 7'd0));
    send_read(5'd1, 7'd0);
  endtask

  // Bursts of text, line breaks, reads, cursor moves and noise
  task automatic run_random();
    int kind;
    int len;
    logic [7:0] b;
    effective = 0;
    while (effective < RAND_ITEMS) begin
      quiet = (effective >= 200 && effective < 320);
      kind  = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(5, 100);
        repeat (len) send_write(8'($urandom_range(32, 126)));
      end else if (kind < 60) begin
        len = $urandom_range(1, 30);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) send_write(CH_CR);
          send_write(CH_LF);
        end
      end else if (kind < 80) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            send_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
          end else begin
            send_read(5'($urandom_range(0, NUM_ROWS - 1)),
                      7'($urandom_range(0, NUM_COLS - 1)));
          end
        end
      end else if (kind < 90) begin
        len = $urandom_range(1, 6);
        repeat (len) send_write(($urandom_range(0, 4) == 0) ? CH_CR : CH_BS);
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          send_item(make_req(1'($urandom_range(0, 1)), b, 5'($urandom_range(0, 31)),
                             7'($urandom_range(0, 127))));
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    quiet       = 1'b0;
    effective   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();
    @(negedge clk);
    req_valid <= 1'b0;

    // Drain, then allow for a trailing scroll
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3 * NUM_COLS) @(posedge clk);

    $display("Covered %0d requests and %0d checked results", accepted, sb.checked);
    $display("Screen scrolled %0d times, %0d right-edge wraps", sb.scrolls, sb.wraps);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ttcw_pkg.sv
design/text_terminal_char_writer_top.sv
tb/text_terminal_char_writer_top_tb.sv
